// File: src/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants of the text console cell writer: request codes,
// decoded command word and character codes.
// ----------------------------------------------------------------------------
package tccw_pkg;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_SET   = 2'd2,
        REQ_READ  = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        CMD_PRINT,
        CMD_BS,
        CMD_TAB,
        CMD_CR,
        CMD_LF,
        CMD_NOP,
        CMD_CLEAR,
        CMD_SET,
        CMD_READ
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  ch;
        logic [6:0]  set_col;
        logic [4:0]  set_row;
        logic [10:0] read_idx;
        logic        read_ok;
    } cmd_t;

    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_TAB     = 8'h09;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  CH_DEL     = 8'h7F;
    localparam logic [15:0] RESET_CELL = 16'h0720;
    localparam logic [7:0]  ATTR_RESET = 8'h07;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;

endpackage

// File: src/text_console_cell_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_top
// Text console engine: ROWS x COLS screen of attribute/character cells with a
// cursor, taking put-character, clear, set-cursor and read-cell requests.
// ----------------------------------------------------------------------------
// Each request returns one result word carrying the read cell (zero unless
// the request is an in-range read) and the cursor after the request. Put
// character, set cursor and read cell first update the screen memory and
// cursor, then form the cursor position product into the result register.
// Clear writes a space in the current attribute to every cell, one memory
// write per cell, then forms the result. A put that moves past the bottom
// row scrolls: it copies each row up by one row through the single write
// port, drains the last copy, fills the bottom row with blanks and then
// forms the result. After reset the screen is cleared to 0x0720 and no
// request is accepted until that is done; attribute writes are taken at any
// time. Two requests can queue ahead of the execution unit.
module text_console_cell_writer_top
    import tccw_pkg::*;
#(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // char_code, set_col, set_row, cell_index
    input  logic [1:0]            s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // cell_value, cursor_col, cursor_row,
                                             // cursor_position
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data   // text_attribute
);

    logic [7:0] attr_reg;
    logic [7:0] attr_next;
    logic       push;
    cmd_t       push_cmd;
    logic       queue_ready;
    logic       pop;
    logic       pop_valid;
    cmd_t       pop_cmd;
    logic       init_done;

    assign cfg_ready = 1'b1;
    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= ATTR_RESET;
        else
            attr_reg <= attr_next;
    end

    tccw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .queue_ready (queue_ready),
        .init_done   (init_done),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    tccw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    tccw_back #(
        .COLS     (COLS),
        .ROWS     (ROWS),
        .TAB_STOP (TAB_STOP)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .attribute (attr_reg),
        .init_done (init_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: src/tccw_front.sv
// ----------------------------------------------------------------------------
// tccw_front
// Input side: accept request words and decode them into commands, with the
// cursor clamp and read range check done up front.
// ----------------------------------------------------------------------------
module tccw_front
    import tccw_pkg::*;
#(
    parameter int COLS = 80,
    parameter int ROWS = 25
)
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // char_code, set_col, set_row, cell_index
    input  logic [1:0]           s_tuser,   // req_type
    input  logic                 queue_ready,
    input  logic                 init_done,
    output logic                 push,
    output cmd_t                 push_cmd
);

    localparam int CELLS = ROWS * COLS;
    localparam logic [6:0] COL_MAX = 7'(COLS - 1);
    localparam logic [4:0] ROW_MAX = 5'(ROWS - 1);

    logic [7:0]  char_code;
    logic [6:0]  set_col;
    logic [4:0]  set_row;
    logic [10:0] cell_index;

    assign char_code  = s_tdata[7:0];
    assign set_col    = s_tdata[14:8];
    assign set_row    = s_tdata[19:15];
    assign cell_index = s_tdata[30:20];

    assign s_tready = queue_ready && init_done;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        push_cmd.ch       = char_code;
        push_cmd.set_col  = (set_col > COL_MAX) ? COL_MAX : set_col;
        push_cmd.set_row  = (32'(set_row) > ROWS - 1) ? ROW_MAX : set_row;
        push_cmd.read_idx = cell_index;
        push_cmd.read_ok  = 32'(cell_index) < CELLS;
        push_cmd.kind     = CMD_NOP;
        unique case (req_t'(s_tuser))
            REQ_PUT:
            begin
                if (char_code == CH_BS)
                    push_cmd.kind = CMD_BS;
                else if (char_code == CH_TAB)
                    push_cmd.kind = CMD_TAB;
                else if (char_code == CH_CR)
                    push_cmd.kind = CMD_CR;
                else if (char_code == CH_LF)
                    push_cmd.kind = CMD_LF;
                else if (char_code >= CH_SPACE && char_code <= CH_DEL)
                    push_cmd.kind = CMD_PRINT;
                else
                    push_cmd.kind = CMD_NOP;
            end
            REQ_CLEAR: push_cmd.kind = CMD_CLEAR;
            REQ_SET:   push_cmd.kind = CMD_SET;
            REQ_READ:  push_cmd.kind = CMD_READ;
        endcase
    end

endmodule

// File: src/tccw_queue.sv
// ----------------------------------------------------------------------------
// tccw_queue
// Two-entry command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
module tccw_queue
    import tccw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic push_ready,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign push_ready = count_reg != 2'd2;
    assign pop_valid  = count_reg != 2'd0;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: src/tccw_back.sv
// ----------------------------------------------------------------------------
// tccw_back
// Execution side: screen memory, cursor, scroll and fill sweeps, and the
// result register.
// ----------------------------------------------------------------------------
module tccw_back
    import tccw_pkg::*;
#(
    parameter int COLS     = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  cmd_t                  cmd,
    output logic                  cmd_pop,
    input  logic [7:0]            attribute,
    output logic                  init_done,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CELLS  = ROWS * COLS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_ADDR     = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLS);
    localparam logic [ADDR_W-1:0] COLS_ADDR     = ADDR_W'(COLS);
    localparam logic [COL_W:0]    COLS_WIDE     = (COL_W + 1)'(COLS);
    localparam logic [ROW_W:0]    ROWS_WIDE     = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCROLL,
        ST_DRAIN,
        ST_FILL,
        ST_EMIT
    } state_t;

    logic [COL_W:0] tab_next [COLS];

    for (genvar g = 0; g < COLS; g++)
    begin : g_tab
        localparam int STOP = (g / TAB_STOP + 1) * TAB_STOP;
        assign tab_next[g] = (COL_W + 1)'((STOP >= COLS) ? COLS : STOP);
    end

    logic [15:0] screen_mem [CELLS];
    logic [15:0] rd_data_reg;

    state_t                  state_reg,        state_next;
    logic [COL_W-1:0]        cur_col_reg,      cur_col_next;
    logic [ROW_W-1:0]        cur_row_reg,      cur_row_next;
    logic [ADDR_W-1:0]       sweep_reg,        sweep_next;
    logic [15:0]             fill_value_reg,   fill_value_next;
    logic                    fill_to_emit_reg, fill_to_emit_next;
    logic                    init_done_reg,    init_done_next;
    logic                    copy_pending_reg, copy_pending_next;
    logic [ADDR_W-1:0]       copy_addr_reg,    copy_addr_next;
    logic                    cell_valid_reg,   cell_valid_next;
    logic [ADDR_W-1:0]       rd_hold_reg,      rd_hold_next;
    logic                    m_tvalid_reg,     m_tvalid_next;
    logic [OUT_DATA_W-1:0]   m_tdata_reg,      m_tdata_next;

    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [15:0]             mem_wdata;
    logic [ADDR_W-1:0]       mem_raddr;

    logic [31:0]             pos_wide;
    logic [ADDR_W-1:0]       cur_pos;
    logic [31:0]             idx_wide;
    logic [ADDR_W-1:0]       cmd_addr;
    logic [31:0]             set_col_wide;
    logic [31:0]             set_row_wide;
    logic [31:0]             col_wide;
    logic [31:0]             row_wide;
    logic [COL_W:0]          col_step;
    logic [ROW_W:0]          row_step;
    logic                    need_scroll;

    assign pos_wide     = 32'(cur_row_reg) * 32'(COLS) + 32'(cur_col_reg);
    assign cur_pos      = pos_wide[ADDR_W-1:0];
    assign idx_wide     = 32'(cmd.read_idx);
    assign cmd_addr     = idx_wide[ADDR_W-1:0];
    assign set_col_wide = 32'(cmd.set_col);
    assign set_row_wide = 32'(cmd.set_row);
    assign col_wide     = 32'(cur_col_reg);
    assign row_wide     = 32'(cur_row_reg);

    assign init_done = init_done_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        col_step = {1'b0, cur_col_reg};
        row_step = {1'b0, cur_row_reg};
        case (cmd.kind)
            CMD_PRINT: col_step = col_step + 1'b1;
            CMD_BS:
            begin
                if (cur_col_reg != '0)
                    col_step = col_step - 1'b1;
            end
            CMD_TAB:   col_step = tab_next[cur_col_reg];
            CMD_CR:    col_step = '0;
            CMD_LF:
            begin
                col_step = '0;
                row_step = row_step + 1'b1;
            end
            default:   col_step = {1'b0, cur_col_reg};
        endcase
        if (col_step >= COLS_WIDE)
        begin
            col_step = '0;
            row_step = row_step + 1'b1;
        end
        need_scroll = row_step >= ROWS_WIDE;
    end

    always_comb
    begin
        state_next        = state_reg;
        cur_col_next      = cur_col_reg;
        cur_row_next      = cur_row_reg;
        sweep_next        = sweep_reg;
        fill_value_next   = fill_value_reg;
        fill_to_emit_next = fill_to_emit_reg;
        init_done_next    = init_done_reg;
        copy_pending_next = 1'b0;
        copy_addr_next    = copy_addr_reg;
        cell_valid_next   = cell_valid_reg;
        rd_hold_next      = rd_hold_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;
        cmd_pop           = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = cur_pos;
        mem_wdata         = {attribute, cmd.ch};
        mem_raddr         = rd_hold_reg;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        if (copy_pending_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = copy_addr_reg;
            mem_wdata = rd_data_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = cmd_addr;
                if (cmd_valid)
                begin
                    cmd_pop         = 1'b1;
                    rd_hold_next    = cmd_addr;
                    cell_valid_next = (cmd.kind == CMD_READ) && cmd.read_ok;
                    state_next      = ST_EMIT;
                    unique case (cmd.kind) inside
                        CMD_PRINT, CMD_BS, CMD_TAB, CMD_CR, CMD_LF, CMD_NOP:
                        begin
                            mem_we       = cmd.kind == CMD_PRINT;
                            cur_col_next = col_step[COL_W-1:0];
                            if (need_scroll)
                            begin
                                cur_row_next = LAST_ROW;
                                sweep_next   = COLS_ADDR;
                                state_next   = ST_SCROLL;
                            end
                            else
                            begin
                                cur_row_next = row_step[ROW_W-1:0];
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cur_col_next      = '0;
                            cur_row_next      = '0;
                            sweep_next        = '0;
                            fill_value_next   = {attribute, CH_SPACE};
                            fill_to_emit_next = 1'b1;
                            state_next        = ST_FILL;
                        end
                        CMD_SET:
                        begin
                            cur_col_next = set_col_wide[COL_W-1:0];
                            cur_row_next = set_row_wide[ROW_W-1:0];
                        end
                        CMD_READ:
                        begin
                            cur_col_next = cur_col_reg;
                        end
                        default:
                        begin
                            cur_col_next = cur_col_reg;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                mem_raddr         = sweep_reg;
                copy_pending_next = 1'b1;
                copy_addr_next    = sweep_reg - COLS_ADDR;
                if (sweep_reg == LAST_ADDR)
                begin
                    sweep_next        = LAST_ROW_BASE;
                    fill_value_next   = {attribute, CH_SPACE};
                    fill_to_emit_next = 1'b1;
                    state_next        = ST_DRAIN;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FILL;
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
                mem_wdata = fill_value_reg;
                if (sweep_reg == LAST_ADDR)
                begin
                    init_done_next = 1'b1;
                    state_next     = fill_to_emit_reg ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, pos_wide[10:0], row_wide[4:0], col_wide[6:0],
                                     cell_valid_reg ? rd_data_reg : 16'h0000};
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= screen_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_FILL;
            cur_col_reg      <= '0;
            cur_row_reg      <= '0;
            sweep_reg        <= '0;
            fill_value_reg   <= RESET_CELL;
            fill_to_emit_reg <= 1'b0;
            init_done_reg    <= 1'b0;
            copy_pending_reg <= 1'b0;
            copy_addr_reg    <= '0;
            cell_valid_reg   <= 1'b0;
            rd_hold_reg      <= '0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cur_col_reg      <= cur_col_next;
            cur_row_reg      <= cur_row_next;
            sweep_reg        <= sweep_next;
            fill_value_reg   <= fill_value_next;
            fill_to_emit_reg <= fill_to_emit_next;
            init_done_reg    <= init_done_next;
            copy_pending_reg <= copy_pending_next;
            copy_addr_reg    <= copy_addr_next;
            cell_valid_reg   <= cell_valid_next;
            rd_hold_reg      <= rd_hold_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_tdata_reg      <= m_tdata_next;
        end
    end

    a_copy_follows_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_pending_reg |-> $past(state_reg) == ST_SCROLL)
        else $error("row copy write without a preceding scroll read");

    a_cursor_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(cur_col_reg) < COLS) && (32'(cur_row_reg) < ROWS))
        else $error("cursor off screen");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_EMIT)
        else $error("result raised outside emit");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL || state_reg == ST_SCROLL) |-> 32'(sweep_reg) < CELLS)
        else $error("sweep address past screen");

endmodule
